[rtl/core/lcdw_pkg.sv]
// shared types, codes and constants for the lcd reading line writer
// used by the controller, the datapath and the top level
`timescale 1ns / 1ps

package lcdw_pkg;

    // operation codes carried on the input tuser
    localparam logic [1:0] OP_TEMP  = 2'd0;
    localparam logic [1:0] OP_HUM   = 2'd1;
    localparam logic [1:0] OP_BAT   = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_TEMP_ADDR = 2'd0;
    localparam logic [1:0] CFG_HUM_ADDR  = 2'd1;
    localparam logic [1:0] CFG_BAT_ADDR  = 2'd2;

    // reset values of the line address registers
    localparam logic [7:0] TEMP_ADDR_RST = 8'h80;
    localparam logic [7:0] HUM_ADDR_RST  = 8'hA0;
    localparam logic [7:0] BAT_ADDR_RST  = 8'hC0;

    // start bytes of the serial link, the clear command and the degree sign
    localparam logic [7:0] START_CMD  = 8'hF8;
    localparam logic [7:0] START_DATA = 8'hFA;
    localparam logic [7:0] CMD_CLEAR  = 8'h01;
    localparam logic [7:0] CH_DEGREE  = 8'hDF;

    // character codes
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_UP_T    = 8'h54;
    localparam logic [7:0] CH_UP_H    = 8'h48;
    localparam logic [7:0] CH_UP_B    = 8'h42;
    localparam logic [7:0] CH_E       = 8'h65;
    localparam logic [7:0] CH_M       = 8'h6D;
    localparam logic [7:0] CH_U       = 8'h75;
    localparam logic [7:0] CH_A       = 8'h61;
    localparam logic [7:0] CH_T       = 8'h74;

    // byte positions within one stream
    localparam int POS_W = 5;
    localparam logic [POS_W-1:0] POS_ADDR_LO    = 5'd2;
    localparam logic [POS_W-1:0] POS_DATA_START = 5'd3;
    localparam logic [POS_W-1:0] POS_LAST_LINE  = 5'd23;
    localparam logic [POS_W-1:0] POS_LAST_CLEAR = 5'd2;

    // decimal conversion: four divide-by-ten steps
    localparam int CONV_W = 3;
    localparam logic [CONV_W-1:0] CONV_STEPS = 3'd4;
    localparam logic [16:0] RECIP_10 = 17'd52429;
    localparam logic [15:0] TENS_LIMIT = 16'd1000;

    // controller to datapath commands
    typedef struct packed {
        logic             load;
        logic             div_step;
        logic             emit;
        logic             last;
        logic [POS_W-1:0] pos;
    } lcdw_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic is_clear;
    } lcdw_status_t;

    // bit order reversal of one byte
    function automatic logic [7:0] flip8(input logic [7:0] v);
        logic [7:0] r;
        for (int k = 0; k < 8; k++)
        begin
            r[7-k] = v[k];
        end
        return r;
    endfunction

endpackage

[rtl/core/lcdw_ctrl.sv]
// sequencer for the lcd reading line writer: byte position and conversion count
// depends on lcdw_pkg
`timescale 1ns / 1ps

module lcdw_ctrl
    import lcdw_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  lcdw_status_t status,
    output lcdw_cmd_t    cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SEND = 1'b1;

    logic              state_reg, state_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [CONV_W-1:0] conv_reg, conv_next;
    logic              oval_reg, oval_next;
    logic              accept, emit, last;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = oval_reg;
    assign accept    = in_valid && in_ready;

    // a byte is built whenever the output slot is free or being drained
    assign emit = (state_reg == ST_SEND) && (!oval_reg || out_ready);
    assign last = status.is_clear ? (pos_reg == POS_LAST_CLEAR)
                                  : (pos_reg == POS_LAST_LINE);

    assign cmd.load     = accept;
    assign cmd.div_step = (state_reg == ST_SEND) && (conv_reg != CONV_STEPS);
    assign cmd.emit     = emit;
    assign cmd.last     = last;
    assign cmd.pos      = pos_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        conv_next  = conv_reg;
        oval_next  = oval_reg;
        if (cmd.div_step)
        begin
            conv_next = conv_reg + 1'b1;
        end
        if (emit)
        begin
            oval_next = 1'b1;
        end
        else if (out_ready)
        begin
            oval_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SEND;
                    pos_next   = '0;
                    conv_next  = '0;
                end
            end
            ST_SEND:
            begin
                if (emit)
                begin
                    pos_next = pos_reg + 1'b1;
                    if (last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            conv_reg  <= CONV_STEPS;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            conv_reg  <= conv_next;
            oval_reg  <= oval_next;
        end
    end

endmodule

[rtl/core/lcdw_dp.sv]
// datapath: line address registers, digit extraction and byte formatting
// depends on lcdw_pkg
`timescale 1ns / 1ps

module lcdw_dp
    import lcdw_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr,
    input  logic [1:0]   cfg_index,
    input  logic [7:0]   cfg_data,
    input  logic [1:0]   operation,
    input  logic [15:0]  reading,
    input  lcdw_cmd_t    cmd,
    output lcdw_status_t status,
    output logic [7:0]   spi_byte,
    output logic         last
);

    logic [7:0]  temp_addr_reg, hum_addr_reg, bat_addr_reg;
    logic [1:0]  op_reg;
    logic        ge1000_reg;
    logic [15:0] x_reg;
    logic [3:0]  dig_reg [4];
    logic [7:0]  byte_reg;
    logic        last_reg;

    logic [32:0] prod;
    logic [13:0] quot;
    logic [16:0] quot10;
    logic [15:0] rem;
    logic [3:0]  char_idx;
    logic [4:0]  pos_m4;
    logic        low_half;
    logic [7:0]  ch, flipped, line_addr;
    logic [7:0]  ch_tens, ch_units, ch_tenths, ch_hund;

    assign status.is_clear = (op_reg == OP_CLEAR);
    assign spi_byte = byte_reg;
    assign last     = last_reg;

    // configuration writes; index three is not a register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_addr_reg <= TEMP_ADDR_RST;
            hum_addr_reg  <= HUM_ADDR_RST;
            bat_addr_reg  <= BAT_ADDR_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                CFG_TEMP_ADDR: temp_addr_reg <= cfg_data;
                CFG_HUM_ADDR:  hum_addr_reg  <= cfg_data;
                CFG_BAT_ADDR:  bat_addr_reg  <= cfg_data;
                default:       ;
            endcase
        end
    end

    // divide by ten through the reciprocal, exact for 16-bit values
    assign prod   = x_reg * RECIP_10;
    assign quot   = prod[32:19];
    assign quot10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
    assign rem    = x_reg - quot10[15:0];

    // item capture and digit shift line, hundredths end up in slot 0
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= operation;
            ge1000_reg <= (reading >= TENS_LIMIT);
            x_reg      <= reading;
        end
        else if (cmd.div_step)
        begin
            x_reg      <= {2'b00, quot};
            dig_reg[3] <= rem[3:0];
            dig_reg[2] <= dig_reg[3];
            dig_reg[1] <= dig_reg[2];
            dig_reg[0] <= dig_reg[1];
        end
    end

    assign ch_hund   = CH_ZERO + {4'h0, dig_reg[0]};
    assign ch_tenths = CH_ZERO + {4'h0, dig_reg[1]};
    assign ch_units  = CH_ZERO + {4'h0, dig_reg[2]};
    assign ch_tens   = ge1000_reg ? (CH_ZERO + {4'h0, dig_reg[3]}) : CH_SPACE;

    assign pos_m4   = cmd.pos - 5'd4;
    assign char_idx = pos_m4[4:1];

    // line address of the selected line
    always_comb
    begin
        unique case (op_reg)
            OP_TEMP: line_addr = temp_addr_reg;
            OP_HUM:  line_addr = hum_addr_reg;
            default: line_addr = bat_addr_reg;
        endcase
    end

    // character at the current position of the line text
    always_comb
    begin
        ch = CH_SPACE;
        if (op_reg == OP_TEMP)
        begin
            case (char_idx)
                4'd0:    ch = CH_UP_T;
                4'd1:    ch = CH_E;
                4'd2:    ch = CH_M;
                4'd3:    ch = CH_COLON;
                4'd4:    ch = ch_tens;
                4'd5:    ch = ch_units;
                4'd6:    ch = CH_DOT;
                4'd7:    ch = ch_tenths;
                4'd8:    ch = ch_hund;
                default: ch = CH_DEGREE;
            endcase
        end
        else
        begin
            case (char_idx)
                4'd0:    ch = (op_reg == OP_HUM) ? CH_UP_H : CH_UP_B;
                4'd1:    ch = (op_reg == OP_HUM) ? CH_U : CH_A;
                4'd2:    ch = (op_reg == OP_HUM) ? CH_M : CH_T;
                4'd3:    ch = CH_COLON;
                4'd4:    ch = CH_SPACE;
                4'd5:    ch = ch_tens;
                4'd6:    ch = ch_units;
                4'd7:    ch = CH_DOT;
                4'd8:    ch = ch_tenths;
                default: ch = CH_PERCENT;
            endcase
        end
        // command byte of the header
        if (cmd.pos < POS_DATA_START)
        begin
            ch = status.is_clear ? CMD_CLEAR : line_addr;
        end
    end

    // nibble split of the reversed character
    assign low_half = (cmd.pos > POS_DATA_START) ? cmd.pos[0] : (cmd.pos == POS_ADDR_LO);
    assign flipped  = flip8(ch);

    // output byte register
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            last_reg <= cmd.last;
            if (cmd.pos == '0)
            begin
                byte_reg <= START_CMD;
            end
            else if (cmd.pos == POS_DATA_START && !status.is_clear)
            begin
                byte_reg <= START_DATA;
            end
            else if (low_half)
            begin
                byte_reg <= {flipped[3:0], 4'h0};
            end
            else
            begin
                byte_reg <= {flipped[7:4], 4'h0};
            end
        end
    end

endmodule

[rtl/core/lcd_reading_line_writer_top.sv]
// top level of the lcd reading line writer
// depends on lcdw_pkg, lcdw_ctrl and lcdw_dp
`timescale 1ns / 1ps

// Formats one reading (in hundredths) as a line for a serial-mode character
// display and streams out the bytes, one per cycle while the sink is ready.
// A line write gives 24 bytes (0xF8, line address, 0xFA, label and value);
// a clear gives 3 bytes; the final byte carries tlast. The input side stays
// busy while an item is sent, output stalls included, and takes no new item
// before that: an item is accepted, then the byte position counter walks the
// stream, one byte a cycle while the sink is ready; the four decimal digits
// come from a divide-by-ten unit that runs one step a cycle alongside the
// header bytes. A new item is taken as soon as the last byte sits in the
// output register. Line addresses are written over the cfg port (index 0
// temperature, 1 humidity, 2 battery; index 3 is ignored).

module lcd_reading_line_writer_top
    import lcdw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] reading
    input  logic [1:0]  s_tuser,   // [1:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] spi_byte
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    lcdw_cmd_t    cmd;
    lcdw_status_t status;

    assign cfg_ready = 1'b1;

    // sequencer
    lcdw_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath
    lcdw_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .operation (s_tuser),
        .reading   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .spi_byte  (m_tdata),
        .last      (m_tlast)
    );

`ifndef ASSERT_OFF
    // conversion starts the cycle after an item is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> cmd.div_step)
    else $error("digit conversion did not start after accept");

    // digits are settled before the value part of a line is formatted
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.pos > POS_DATA_START && !status.is_clear) |-> !cmd.div_step)
    else $error("value byte formatted while conversion still running");

    // the block is free again right after the final byte is loaded
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.last) |=> (s_tready && m_tvalid && m_tlast))
    else $error("final byte not followed by a free input side");

    // every stream opens with the command start byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.pos == '0) |=> (m_tdata == START_CMD && !m_tlast))
    else $error("stream did not open with the command start byte");
`endif

endmodule
